### rtl/snfa_pkg.sv
// ----------------------------------------------------------------------------
// snfa_pkg: shared types and constants
// Action codes and field widths for the spring network force accumulator.
// ----------------------------------------------------------------------------
package snfa_pkg;
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_EDGE   = 2'd1,
    ACT_RDNODE = 2'd2,
    ACT_RDEN   = 2'd3
  } action_t;

  localparam int IDX_W = 10;
  localparam int POS_W = 32;
  localparam int ACC_W = 48;

  typedef struct packed {
    action_t                   action;
    logic [IDX_W-1:0]          node_index;
    logic [IDX_W-1:0]          other_node;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic                      is_fixed;
    logic [31:0]               rest_length;
    logic [15:0]               spring_constant;
  } req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] force_x;
    logic signed [ACC_W-1:0] force_y;
    logic [ACC_W-1:0]        energy;
    logic                    degenerate_edge;
    logic                    saturated;
  } rsp_t;
endpackage

### rtl/snfa_if.sv
// ----------------------------------------------------------------------------
// snfa_req_if / snfa_rsp_if: valid-ready channels
// Carry requests into the block and results out of it.
// ----------------------------------------------------------------------------
interface snfa_req_if;
  import snfa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface snfa_rsp_if;
  import snfa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/spring_network_force_accumulate.sv
// ----------------------------------------------------------------------------
// spring_network_force_accumulate: harmonic spring force accumulator
// Node table, per-node force sums and an energy sum, driven by one sequencer.
// ----------------------------------------------------------------------------
// One request is handled at a time. The next request is accepted only once
// the block is idle and the previous result has been taken. A node write and
// the energy read go straight to the output state, and a node read passes
// through S_RDN first. An edge request runs through two position reads, the
// deltas and the squared length, a restoring square root (33 steps), the
// spring factor, and for each axis a serial multiply for the numerator and a
// restoring division of 88 steps in one shared subtract/compare unit. After
// that come the energy and read-modify-write of both endpoint accumulators
// through the one memory port. A zero-length edge stops after the root.
// After reset the block clears the force memories and takes no request
// meanwhile. Positions are undefined until written.
module spring_network_force_accumulate #(
  parameter int MAX_NODES = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  snfa_req_if.sink   in_ch,
  snfa_rsp_if.source out_ch
);
  import snfa_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam logic signed [ACC_W-1:0] FMAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] FMIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD1, S_RD2, S_SQ, S_ROOT, S_KD, S_NUMX, S_DIVX,
    S_NUMY, S_DIVY, S_EN, S_UPA, S_UPA2, S_UPB, S_UPB2, S_RDN, S_OUT
  } state_t;

  // Memories.
  logic [2*POS_W-1:0] pos_mem [MAX_NODES];
  logic               fix_mem [MAX_NODES];
  logic [ACC_W-1:0]   fx_mem  [MAX_NODES];
  logic [ACC_W-1:0]   fy_mem  [MAX_NODES];

  state_t state_r;
  req_t   req_r;
  logic   slides_r;
  logic [AW:0] clr_r;
  logic [ACC_W-1:0] energy_r;
  rsp_t   rsp_r;
  logic   out_valid_r;

  // Memory port.
  logic [AW-1:0] raddr;
  logic [2*POS_W-1:0] pos_q_r;
  logic               fix_q_r;
  logic [ACC_W-1:0]   fx_q_r, fy_q_r;
  logic               mwe;
  logic [AW-1:0]      maddr;
  logic [ACC_W-1:0]   mfx, mfy;

  // Datapath registers.
  logic signed [POS_W:0] ax_r, ay_r, dx_r, dy_r; // first position, then deltas
  logic [65:0]  rad_r;     // squared length
  logic [66:0]  rrem_r;
  logic [32:0]  root_r;
  logic [5:0]   cnt_r;
  logic signed [49:0] kd_r;
  logic [127:0] num_r;     // dividend shifting out
  logic [127:0] q_r;
  logic [63:0]  drem_r;
  logic signed [ACC_W+16:0] fx_r, fy_r;
  logic         sat_r, degen_r;
  logic [6:0]   step_r;

  wire idx_a_ok = 32'(req_r.node_index) < 32'(MAX_NODES);
  wire idx_b_ok = 32'(req_r.other_node) < 32'(MAX_NODES);
  wire in_acc   = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    pos_q_r <= pos_mem[raddr];
    fix_q_r <= fix_mem[raddr];
    fx_q_r  <= fx_mem[raddr];
    fy_q_r  <= fy_mem[raddr];
    if (mwe) begin
      fx_mem[maddr] <= mfx;
      fy_mem[maddr] <= mfy;
    end
    if (in_acc && in_ch.data.action == ACT_WRITE &&
        32'(in_ch.data.node_index) < 32'(MAX_NODES)) begin
      pos_mem[AW'(in_ch.data.node_index)] <= {in_ch.data.pos_x, in_ch.data.pos_y};
      fix_mem[AW'(in_ch.data.node_index)] <= in_ch.data.is_fixed;
    end else if (state_r == S_CLR) begin
      fix_mem[clr_r[AW-1:0]] <= 1'b0;
    end
  end

  // While idle the port already looks at the incoming request's node, so a
  // node read finds its sums in the next cycle.
  always_comb begin
    unique case (state_r)
      S_IDLE:               raddr = AW'(in_ch.data.node_index);
      S_UPB, S_UPB2, S_RD2: raddr = AW'(req_r.other_node);
      default:              raddr = AW'(req_r.node_index);
    endcase
  end

  // Saturating add.
  function automatic logic [ACC_W:0] sadd(logic [ACC_W-1:0] a,
                                          logic signed [ACC_W+16:0] b);
    logic signed [ACC_W+17:0] s;
    s = $signed({{18{a[ACC_W-1]}}, a}) + $signed({b[ACC_W+16], b});
    if (s > $signed((ACC_W+18)'(FMAX))) return {1'b1, FMAX};
    if (s < $signed({{18{1'b1}}, FMIN})) return {1'b1, FMIN};
    return {1'b0, s[ACC_W-1:0]};
  endfunction

  logic [ACC_W:0] sax, say;
  logic apply_x, apply_y;
  logic signed [ACC_W+16:0] fxs, fys;
  always_comb begin
    fxs = (state_r == S_UPB2) ? -fx_r : fx_r;
    fys = (state_r == S_UPB2) ? -fy_r : fy_r;
    sax = sadd(fx_q_r, fxs);
    say = sadd(fy_q_r, fys);
    apply_x = !fix_q_r || slides_r;
    apply_y = !fix_q_r;
    mwe = 1'b0;
    maddr = raddr;
    mfx = fx_q_r;
    mfy = fy_q_r;
    unique case (state_r)
      S_CLR: begin
        mwe = 1'b1; maddr = clr_r[AW-1:0]; mfx = '0; mfy = '0;
      end
      S_UPA2, S_UPB2: begin
        mwe = 1'b1;
        if (apply_x) mfx = sax[ACC_W-1:0];
        if (apply_y) mfy = say[ACC_W-1:0];
      end
      S_RDN: begin
        mwe = idx_a_ok; mfx = '0; mfy = '0;
      end
      default: ;
    endcase
  end

  // Shared subtract/compare unit. The numerator stays below 2^88, so the
  // division brings in dividend bits from bit 87 downward.
  logic [66:0] sub_a, sub_b, sub_d;
  logic        sub_ge;
  always_comb begin
    if (state_r == S_ROOT) begin
      sub_a = {rrem_r[64:0], rad_r[65:64]};
      sub_b = {32'd0, root_r, 2'b01};
    end else begin
      sub_a = {2'b0, drem_r, num_r[87]};
      sub_b = {2'b0, 24'd0, root_r, 8'd0};
    end
    sub_d  = sub_a - sub_b;
    sub_ge = sub_a >= sub_b;
  end

  // Magnitudes.
  logic [32:0] mdx, mdy;
  logic [49:0] mkd;
  logic [33:0] mdiff;
  logic signed [33:0] diff;
  assign mdx  = dx_r[POS_W] ? 33'(-dx_r) : 33'(dx_r);
  assign mdy  = dy_r[POS_W] ? 33'(-dy_r) : 33'(dy_r);
  assign mkd  = kd_r[49] ? 50'(-kd_r) : 50'(kd_r);
  assign diff = $signed({1'b0, root_r}) - $signed({2'b0, req_r.rest_length});
  assign mdiff = diff[33] ? 34'(-diff) : 34'(diff);

  // One 33x33 multiply is shared; a wide operand is fed in a low 32-bit piece and an upper piece.
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  always_comb begin
    mul_a = '0; mul_b = '0;
    unique case (state_r)
      S_SQ:   begin mul_a = step_r[0] ? mdy : mdx; mul_b = mul_a; end
      S_NUMX: begin mul_a = step_r[0] ? 33'(mkd[49:32]) : {1'b0, mkd[31:0]}; mul_b = mdx; end
      S_NUMY: begin mul_a = step_r[0] ? 33'(mkd[49:32]) : {1'b0, mkd[31:0]}; mul_b = mdy; end
      S_EN:   begin
        mul_a = step_r[1] ? 33'(mdiff[33:32]) : {1'b0, mdiff[31:0]};
        mul_b = step_r[0] ? 33'(mdiff[33:32]) : {1'b0, mdiff[31:0]};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  logic [67:0] d2_r; // diff squared
  logic [83:0] e_prod;
  assign e_prod = d2_r * req_r.spring_constant;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      slides_r    <= 1'b0;
      energy_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) slides_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + (AW+1)'(1);
          if (clr_r == (AW+1)'(MAX_NODES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_acc) begin
          req_r   <= in_ch.data;
          sat_r   <= 1'b0;
          degen_r <= 1'b0;
          rsp_r   <= rsp_t'{
            force_x:         '0,
            force_y:         '0,
            energy:          (in_ch.data.action == ACT_RDEN) ? energy_r : '0,
            degenerate_edge: 1'b0,
            saturated:       1'b0
          };
          unique case (in_ch.data.action)
            ACT_WRITE:  state_r <= S_OUT;
            ACT_EDGE:   state_r <= S_RD1;
            ACT_RDNODE: state_r <= S_RDN;
            ACT_RDEN:   begin
              energy_r     <= '0;
              state_r      <= S_OUT;
            end
          endcase
        end
        S_RDN: begin
          if (idx_a_ok) begin
            state_r <= S_OUT;
            rsp_r.force_x <= fx_q_r;
            rsp_r.force_y <= fy_q_r;
          end else state_r <= S_OUT;
        end
        S_RD1: begin
          if (!(idx_a_ok && idx_b_ok)) state_r <= S_OUT;
          else state_r <= S_RD2;
        end
        S_RD2: begin
          // pos_q_r holds node a here
          ax_r <= $signed({pos_q_r[63], pos_q_r[63:32]});
          ay_r <= $signed({pos_q_r[31], pos_q_r[31:0]});
          state_r <= S_SQ;
          step_r <= '0;
        end
        S_SQ: begin
          if (step_r == 7'd0) begin
            dx_r <= $signed({pos_q_r[63], pos_q_r[63:32]}) - ax_r;
            dy_r <= $signed({pos_q_r[31], pos_q_r[31:0]}) - ay_r;
            step_r <= 7'd2;
          end else if (step_r == 7'd2) begin
            rad_r <= 66'(mul_p); step_r <= 7'd3;
          end else begin
            rad_r  <= rad_r + 66'(mul_p);
            rrem_r <= '0; root_r <= '0; cnt_r <= 6'd33;
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          rad_r <= {rad_r[63:0], 2'b00};
          if (sub_ge) begin
            rrem_r <= sub_d; root_r <= {root_r[31:0], 1'b1};
          end else begin
            rrem_r <= sub_a; root_r <= {root_r[31:0], 1'b0};
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= S_KD;
        end
        S_KD: begin
          if (root_r == '0) begin
            degen_r <= 1'b1; state_r <= S_OUT;
          end else begin
            kd_r <= $signed({16'd0, req_r.spring_constant}) * diff;
            step_r <= '0; state_r <= S_NUMX;
          end
        end
        S_NUMX, S_NUMY: begin
          if (step_r == 7'd0) begin
            num_r <= 128'(mul_p); step_r <= 7'd1;
          end else begin
            num_r <= num_r + {mul_p, 32'd0};
            drem_r <= '0; q_r <= '0; step_r <= 7'd0;
            state_r <= (state_r == S_NUMX) ? S_DIVX : S_DIVY;
          end
        end
        S_DIVX, S_DIVY: begin
          num_r  <= {num_r[126:0], 1'b0};
          drem_r <= sub_ge ? sub_d[63:0] : sub_a[63:0];
          q_r    <= {q_r[126:0], sub_ge};
          step_r <= step_r + 7'd1;
          if (step_r == 7'd87) begin
            if (state_r == S_DIVX) begin
              fx_r <= (kd_r[49] ^ dx_r[POS_W]) ? -$signed({1'b0, q_r[62:0], sub_ge}) :
                      $signed({1'b0, q_r[62:0], sub_ge});
              step_r <= '0; state_r <= S_NUMY;
            end else begin
              fy_r <= (kd_r[49] ^ dy_r[POS_W]) ? -$signed({1'b0, q_r[62:0], sub_ge}) :
                      $signed({1'b0, q_r[62:0], sub_ge});
              step_r <= '0; d2_r <= '0; state_r <= S_EN;
            end
          end
        end
        S_EN: begin
          step_r <= step_r + 7'd1;
          unique case (step_r[2:0])
            3'd0: d2_r <= 68'(mul_p);
            3'd1, 3'd2: d2_r <= d2_r + {mul_p[35:0], 32'd0};
            3'd3: d2_r <= d2_r + {mul_p[3:0], 64'd0};
            default: begin
              // e = k*diff^2 >> 25, clipped into the energy sum.
              if ((49'(energy_r) + 49'(e_prod[83:25])) > 49'({ACC_W{1'b1}}) ||
                  |e_prod[83:73]) begin
                energy_r <= '1; sat_r <= 1'b1;
              end else energy_r <= energy_r + e_prod[72:25];
              state_r <= S_UPA;
            end
          endcase
        end
        S_UPA:  state_r <= S_UPA2;
        S_UPA2: begin
          if ((apply_x && sax[ACC_W]) || (apply_y && say[ACC_W])) sat_r <= 1'b1;
          state_r <= S_UPB;
        end
        S_UPB:  state_r <= S_UPB2;
        S_UPB2: begin
          if ((apply_x && sax[ACC_W]) || (apply_y && say[ACC_W])) sat_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_ch.ready) begin
          rsp_r.degenerate_edge <= degen_r;
          rsp_r.saturated <= sat_r;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = rsp_r;

  // Assertions.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ch.ready) else $error("accept during clear");
  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROOT |-> cnt_r != 6'd0) else $error("root count ran out");
  a_deg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.degenerate_edge |-> !out_ch.data.saturated)
    else $error("degenerate edge flagged saturation");
endmodule

### test/snfa_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snfa_tb_if: testbench limits for the result channel
// The channel interfaces live with the RTL; this file only holds shared
// testbench constants for the result limits.
// ----------------------------------------------------------------------------
package snfa_tb_pkg;
  import snfa_pkg::*;

  // Largest positive and negative force sums; the energy sum saturates at all ones.
  localparam logic signed [ACC_W-1:0] FORCE_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] FORCE_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0]        ENERGY_MAX = {ACC_W{1'b1}};
endpackage

### test/tb_spring_network_force_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spring_network_force_accumulate: self-checking bench for the force block
// Drives node writes, spring edges and read-and-clear requests with random
// gaps on both channels. A scoreboard keeps its own node table and
// accumulators, predicts each result and compares the results field by field.
// ----------------------------------------------------------------------------
module tb_spring_network_force_accumulate;
  import snfa_pkg::*;
  import snfa_tb_pkg::*;

  localparam int NODES     = 1024;
  localparam int CFG_INDEX = 0;
  localparam int WDOG_MAX  = 20000;
  localparam int EDGE_LAT  = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  snfa_req_if in_ch ();
  snfa_rsp_if out_ch ();

  spring_network_force_accumulate #(.MAX_NODES(NODES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // The scoreboard models the node table and the accumulators, and keeps a
  // queue of predicted results in the order the requests were accepted.
  class force_scoreboard;
    logic signed [31:0] pos_x_tab [NODES];
    logic signed [31:0] pos_y_tab [NODES];
    bit                 fixed_tab [NODES];
    logic signed [47:0] fx_sum [NODES];
    logic signed [47:0] fy_sum [NODES];
    logic [47:0]        energy_acc;
    bit                 slides_x;
    rsp_t               pending [$];
    int                 errors;

    function void clear();
      for (int i = 0; i < NODES; i++) begin
        pos_x_tab[i] = '0;
        pos_y_tab[i] = '0;
        fixed_tab[i] = 1'b0;
        fx_sum[i]    = '0;
        fy_sum[i]    = '0;
      end
      energy_acc = '0;
      slides_x   = 1'b0;
      pending.delete();
      errors = 0;
    endfunction

    // Adds into a force sum, clipping at the signed 48-bit limits.
    function void add_clip(ref logic signed [47:0] acc, input logic signed [127:0] v,
                           ref bit sat);
      logic signed [127:0] s;
      s = 128'(signed'(acc)) + v;
      if (s > 128'(signed'(FORCE_MAX))) begin
        s = 128'(signed'(FORCE_MAX));
        sat = 1'b1;
      end
      if (s < 128'(signed'(FORCE_MIN))) begin
        s = 128'(signed'(FORCE_MIN));
        sat = 1'b1;
      end
      acc = s[47:0];
    endfunction

    function void push_force(int n, logic signed [127:0] fx, logic signed [127:0] fy,
                             ref bit sat);
      if (!fixed_tab[n]) begin
        add_clip(fx_sum[n], fx, sat);
        add_clip(fy_sum[n], fy, sat);
      end else if (slides_x) begin
        add_clip(fx_sum[n], fx, sat);
      end
    endfunction

    // Quotient of k*diff*delta over d*256, truncated toward zero.
    function logic signed [127:0] axis_force(logic signed [127:0] kd,
                                             logic signed [127:0] delta,
                                             logic [127:0] d);
      logic [127:0] mk;
      logic [127:0] md;
      logic [127:0] q;
      mk = kd < 0 ? -kd : kd;
      md = delta < 0 ? -delta : delta;
      q  = (mk * md) / (d << 8);
      q  = q[63:0];
      return ((kd < 0) != (delta < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function logic [127:0] int_sqrt(logic [127:0] v);
      logic [127:0] r;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= v) r = r | (128'd1 << b);
      end
      return r;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(req_t r);
      rsp_t exp_rsp;
      int a;
      int b;
      bit sat;
      logic signed [127:0] dx;
      logic signed [127:0] dy;
      logic signed [127:0] diff;
      logic signed [127:0] kd;
      logic signed [127:0] fx;
      logic signed [127:0] fy;
      logic [127:0] d;
      logic [127:0] e;
      logic [127:0] en;
      exp_rsp = '0;
      sat = 1'b0;
      a = int'(r.node_index);
      b = int'(r.other_node);
      case (r.action)
        ACT_WRITE: begin
          pos_x_tab[a] = r.pos_x;
          pos_y_tab[a] = r.pos_y;
          fixed_tab[a] = r.is_fixed;
        end
        ACT_EDGE: begin
          dx = 128'(signed'(pos_x_tab[b])) - 128'(signed'(pos_x_tab[a]));
          dy = 128'(signed'(pos_y_tab[b])) - 128'(signed'(pos_y_tab[a]));
          d  = int_sqrt(dx * dx + dy * dy);
          if (d == 0) begin
            exp_rsp.degenerate_edge = 1'b1;
          end else begin
            diff = $signed(d) - $signed({96'd0, r.rest_length});
            kd   = $signed({112'd0, r.spring_constant}) * diff;
            fx   = axis_force(kd, dx, d);
            fy   = axis_force(kd, dy, d);
            push_force(a, fx, fy, sat);
            push_force(b, -fx, -fy, sat);
            e  = (diff * diff * r.spring_constant) >> 25;
            en = {80'd0, energy_acc} + e;
            if (en > {80'd0, ENERGY_MAX}) begin
              en  = {80'd0, ENERGY_MAX};
              sat = 1'b1;
            end
            energy_acc = en[47:0];
          end
        end
        ACT_RDNODE: begin
          exp_rsp.force_x = fx_sum[a];
          exp_rsp.force_y = fy_sum[a];
          fx_sum[a] = '0;
          fy_sum[a] = '0;
        end
        default: begin
          exp_rsp.energy = energy_acc;
          energy_acc = '0;
        end
      endcase
      exp_rsp.saturated = sat;
      pending.insert(pending.size(), exp_rsp);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(rsp_t got);
      rsp_t w;
      if (pending.size() == 0) begin
        $error("unexpected result force_x=%0d", got.force_x);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.force_x !== w.force_x) begin
        $error("force_x expected %0d actual %0d", w.force_x, got.force_x);
        errors++;
      end
      if (got.force_y !== w.force_y) begin
        $error("force_y expected %0d actual %0d", w.force_y, got.force_y);
        errors++;
      end
      if (got.energy !== w.energy) begin
        $error("energy expected %0d actual %0d", w.energy, got.energy);
        errors++;
      end
      if (got.degenerate_edge !== w.degenerate_edge) begin
        $error("degenerate_edge expected %0b actual %0b", w.degenerate_edge,
               got.degenerate_edge);
        errors++;
      end
      if (got.saturated !== w.saturated) begin
        $error("saturated expected %0b actual %0b", w.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  force_scoreboard sb;
  bit   written [NODES];
  int   written_list [$];
  int   idle_cycles = 0;
  bit   timed_out;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Most gaps are zero or short; now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // The result side stalls independently of the request side.
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Results are sampled at the edge; the monitor also feeds the watchdog,
  // which counts cycles in which neither channel moved a request or result.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drives one request and holds it until accepted. Valid stays high when
  // the next request follows with no gap, so it is never lowered and raised
  // in the same step.
  task automatic send_request(req_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.data  <= r;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    if (r.action == ACT_WRITE) begin
      if (!written[r.node_index]) written_list.insert(written_list.size(), int'(r.node_index));
      written[r.node_index] = 1'b1;
    end
  endtask

  // Waits until the block has returned every predicted result, then lets the
  // block settle so that a register write meets an idle block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slides(bit v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.slides_x = v;
  endtask

  task automatic node_write(int n, logic [31:0] x, logic [31:0] y, bit fx);
    req_t r;
    r = '0;
    r.action     = ACT_WRITE;
    r.node_index = IDX_W'(n);
    r.pos_x      = x;
    r.pos_y      = y;
    r.is_fixed   = fx;
    r.other_node = IDX_W'($urandom);
    r.rest_length = $urandom;
    r.spring_constant = 16'($urandom);
    send_request(r);
  endtask

  task automatic edge_req(int a, int b, logic [31:0] l0, logic [15:0] k);
    req_t r;
    r = '0;
    r.action          = ACT_EDGE;
    r.node_index      = IDX_W'(a);
    r.other_node      = IDX_W'(b);
    r.rest_length     = l0;
    r.spring_constant = k;
    r.pos_x           = $urandom;
    r.pos_y           = $urandom;
    r.is_fixed        = 1'($urandom);
    send_request(r);
  endtask

  task automatic read_req(action_t act, int n);
    req_t r;
    r = '0;
    r.action     = act;
    r.node_index = IDX_W'(n);
    r.other_node = IDX_W'($urandom);
    send_request(r);
  endtask

  // A node that has a known position, so edges never read unwritten entries.
  function automatic int pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // Coordinates: mostly modest, sometimes the full 32-bit range.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000) << 6;
    endcase
  endfunction

  task automatic random_phase(int count);
    int sel;
    int n;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 25 || written_list.size() < 2) begin
        n = (sel < 5 && written_list.size() > 0) ? pick_written() : $urandom_range(0, 63);
        if ($urandom_range(0, 19) == 0) n = $urandom_range(0, NODES - 1);
        node_write(n, rand_coord(), rand_coord(), $urandom_range(0, 3) == 0);
      end else if (sel < 70) begin
        edge_req(pick_written(), pick_written(),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0100_0000),
                 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024)));
      end else if (sel < 92) begin
        read_req(ACT_RDNODE, $urandom_range(0, 4) == 0 ? $urandom_range(0, NODES - 1)
                                                       : pick_written());
      end else begin
        read_req(ACT_RDEN, int'($urandom_range(0, NODES - 1)));
      end
    end
  endtask

  // Reset, request stimulus and stall watchdog.
  initial begin
    sb = new();
    sb.clear();
    timed_out   = 1'b0;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (NODES + 20) @(posedge clk);

    fork
      begin
        // Directed part: extreme coordinates, coincident and same-node edges,
        // fixed endpoints, saturation of the accumulators and both reads.
        write_slides(1'b0);
        node_write(0, 32'h0000_0000, 32'h0000_0000, 1'b0);
        node_write(1, 32'h0003_0000, 32'h0004_0000, 1'b0);
        node_write(2, 32'h0000_0000, 32'h0000_0000, 1'b1);
        node_write(NODES - 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        node_write(3, 32'h8000_0000, 32'h8000_0000, 1'b1);
        edge_req(0, 1, 32'h0001_0000, 16'h0100);
        edge_req(0, 0, 32'h0, 16'hFFFF);
        edge_req(0, 2, 32'h0, 16'hFFFF);
        edge_req(1, 2, 32'hFFFF_FFFF, 16'hFFFF);
        edge_req(NODES - 1, 3, 32'h0, 16'hFFFF);
        edge_req(NODES - 1, 3, 32'h0, 16'hFFFF);
        edge_req(3, NODES - 1, 32'hFFFF_FFFF, 16'hFFFF);
        read_req(ACT_RDNODE, 0);
        read_req(ACT_RDNODE, 3);
        read_req(ACT_RDNODE, NODES - 1);
        read_req(ACT_RDEN, 0);
        read_req(ACT_RDEN, 0);
        write_slides(1'b1);
        edge_req(1, 3, 32'h0000_8000, 16'h0080);
        edge_req(3, 1, 32'h0000_0000, 16'h0000);
        read_req(ACT_RDNODE, 3);
        read_req(ACT_RDNODE, 1);

        random_phase(300);
        write_slides(1'b0);
        random_phase(300);
        // The sender pauses here until every result is back.
        write_slides(1'b1);
        random_phase(300);
        drain();
        repeat (EDGE_LAT) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
          $display("spring_network_force_accumulate verification clean");
        end else begin
          $display("spring_network_force_accumulate verification failed");
        end
        $finish;
      end
      begin
        wait (idle_cycles >= WDOG_MAX);
        timed_out = 1'b1;
        $display("spring_network_force_accumulate verification failed");
        $finish;
      end
    join
  end
endmodule
